@@ rtl/radix_digit_converter_core_assert.svh @@
// Assertion macros for the radix digit converter
`ifndef RADIX_DIGIT_CONVERTER_CORE_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during rst
`define RDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdc assertion failed");

// next-cycle implication, clocked on clk, quiet during rst
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdc assertion failed");

`endif

@@ rtl/rdc_pkg.sv @@
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int STEP_BITS      = 8;
  localparam int RADIX_W        = 5;
  localparam int CHAR_W         = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A_OFS = 7'd87;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_BAD
  } rdc_state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic emit;
    logic emit_bad;
  } rdc_cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic div_last;
    logic quo_zero;
    logic cnt_one;
    logic slot_free;
  } rdc_status_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A_OFS + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

@@ rtl/radix_digit_converter_core.sv @@
`timescale 1ns / 1ps
// Flow: the item is taken in, then each digit is found by restoring division by the
// radix (eight quotient bits a cycle); once the quotient is zero, the digits leave
// through the output register, most significant first, as out_ready takes them.
// One item at a time; an invalid radix gives a single zero digit flagged bad_radix.
// Reset clears the controller and the output valid flag; no clearing pass.
`include "radix_digit_converter_core_assert.svh"

module radix_digit_converter_core
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last,
  output logic                  bad_radix
);

  rdc_cmd_t    cmd;
  rdc_status_t status;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rdc_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .radix      (radix),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last),
    .bad_radix  (bad_radix)
  );

  `RDC_ASSERT_NOW(a_bad_is_single_zero, out_valid && bad_radix, last && digit_char == CHAR_ZERO)
  `RDC_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `RDC_ASSERT_NOW(a_mid_item_busy, out_valid && !last, !in_ready)

endmodule

@@ rtl/rdc_ctrl.sv @@
`timescale 1ns / 1ps

module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rdc_status_t status,
  output rdc_cmd_t    cmd
);

  rdc_state_t state;
  rdc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.radix_bad ? ST_BAD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_last && status.quo_zero) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.slot_free && status.cnt_one) begin
          state_next = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV:  cmd.div      = 1'b1;
      ST_EMIT: cmd.emit     = status.slot_free;
      ST_BAD:  cmd.emit_bad = status.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/rdc_dpath.sv @@
`timescale 1ns / 1ps

module rdc_dpath
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  input  rdc_cmd_t              cmd,
  output rdc_status_t           status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last,
  output logic                  bad_radix
);

  localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS   = STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int STACK_W    = 4 * VALUE_BITS;

  logic [PAD_BITS-1:0]   quo;
  logic [PAD_BITS-1:0]   quo_next;
  logic [3:0]            rem;
  logic [3:0]            rem_next;
  logic [RADIX_W-1:0]    radix_q;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0]      cnt;
  logic [STACK_W-1:0]    stack;
  logic [STEP_BITS-1:0]  qbits;

  // restoring division, STEP_BITS quotient bits a cycle, MSB first
  always_comb begin
    logic [4:0] acc;
    logic [3:0] r;
    r     = rem;
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      acc = {r, quo[PAD_BITS-1-i]};
      if (acc >= radix_q) begin
        acc = acc - radix_q;
        qbits[STEP_BITS-1-i] = 1'b1;
      end
      r = acc[3:0];
    end
    rem_next = r;
    quo_next = (quo << STEP_BITS) | PAD_BITS'(qbits);
  end

  always_comb begin
    status.radix_bad = !(radix inside {[RADIX_MIN:RADIX_MAX]});
    status.div_last  = (step_cnt == STEP_CNT_W'(STEPS - 1));
    status.quo_zero  = (quo_next == '0);
    status.cnt_one   = (cnt == CNT_W'(1));
    status.slot_free = !out_valid || out_ready;
  end

  // digit stack: push at the bottom nibble, pop from it
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo      <= PAD_BITS'(value);
      rem      <= '0;
      radix_q  <= radix;
      step_cnt <= '0;
      cnt      <= '0;
    end else if (cmd.div) begin
      quo <= quo_next;
      if (status.div_last) begin
        rem      <= '0;
        step_cnt <= '0;
        stack    <= {stack[STACK_W-5:0], rem_next};
        cnt      <= cnt + CNT_W'(1);
      end else begin
        rem      <= rem_next;
        step_cnt <= step_cnt + STEP_CNT_W'(1);
      end
    end else if (cmd.emit) begin
      stack <= stack >> 4;
      cnt   <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_bad) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_char <= digit_to_char(stack[3:0]);
      last       <= status.cnt_one;
      bad_radix  <= 1'b0;
    end else if (cmd.emit_bad) begin
      digit_char <= CHAR_ZERO;
      last       <= 1'b1;
      bad_radix  <= 1'b1;
    end
  end

endmodule

@@ test/radix_digit_converter_core_tb.sv @@
`timescale 1ns / 1ps

module radix_digit_converter_core_tb;
  import rdc_pkg::*;

  localparam int VB          = VALUE_BITS_DEF;
  localparam int RANDOM_ITEMS = 405;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 300;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } digit_t;

  typedef digit_t digit_q_t[$];

  typedef struct {
    logic [VB-1:0]      number;
    logic [RADIX_W-1:0] base;
    string              spelled;
    logic               flagged;
  } row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [VB-1:0]      value;
  logic [RADIX_W-1:0] radix;
  logic               out_valid;
  logic               out_ready;
  logic [CHAR_W-1:0]  digit_char;
  logic               last;
  logic               bad_radix;

  digit_t pending_digits[$];
  int     mismatches = 0;
  int     rx_count = 0;
  bit     quiet_tx = 1'b0;

  // empty spelling: expectation comes from the predictor
  row_t plan [25] = '{
    '{32'd0,          5'd10, "0",                                1'b0},
    '{32'd0,          5'd0,  "0",                                1'b1},
    '{32'd5,          5'd1,  "0",                                1'b1},
    '{32'd123,        5'd17, "0",                                1'b1},
    '{32'hFFFF_FFFF,  5'd31, "0",                                1'b1},
    '{32'hFFFF_FFFF,  5'd2,  "11111111111111111111111111111111", 1'b0},
    '{32'hFFFF_FFFF,  5'd16, "ffffffff",                         1'b0},
    '{32'hFFFF_FFFF,  5'd10, "4294967295",                       1'b0},
    '{32'd0,          5'd2,  "0",                                1'b0},
    '{32'd1,          5'd2,  "1",                                1'b0},
    '{32'd15,         5'd16, "f",                                1'b0},
    '{32'd16,         5'd16, "10",                               1'b0},
    '{32'h8000_0000,  5'd2,  "",                                 1'b0},
    '{32'd1234567890, 5'd3,  "",                                 1'b0},
    '{32'd1234567890, 5'd4,  "",                                 1'b0},
    '{32'd1234567890, 5'd5,  "",                                 1'b0},
    '{32'd1234567890, 5'd6,  "",                                 1'b0},
    '{32'd1234567890, 5'd7,  "",                                 1'b0},
    '{32'd1234567890, 5'd8,  "",                                 1'b0},
    '{32'd1234567890, 5'd9,  "",                                 1'b0},
    '{32'd1234567890, 5'd11, "",                                 1'b0},
    '{32'd1234567890, 5'd12, "",                                 1'b0},
    '{32'd1234567890, 5'd13, "",                                 1'b0},
    '{32'd1234567890, 5'd14, "",                                 1'b0},
    '{32'hDEAD_BEEF,  5'd15, "",                                 1'b0}
  };

  radix_digit_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .radix     (radix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digit_char(digit_char),
    .last      (last),
    .bad_radix (bad_radix)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic digit_q_t spell_number(input logic [VB-1:0] v,
                                            input logic [RADIX_W-1:0] r);
    digit_q_t    res;
    logic [VB-1:0] rest;
    logic [3:0]  d;
    digit_t      item;
    res = {};
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      item = '{CHAR_ZERO, 1'b1, 1'b1};
      res.push_back(item);
      return res;
    end
    rest = v;
    do begin
      d = 4'(rest % VB'(r));
      item.ch   = (d < 4'd10) ? 7'(8'h30 + 8'(d)) : 7'(8'h61 + 8'(d) - 8'd10);
      item.last = 1'b0;
      item.bad  = 1'b0;
      res.push_front(item);
      rest = rest / VB'(r);
    end while (rest != '0);
    res[res.size()-1].last = 1'b1;
    return res;
  endfunction

  task automatic offer(input logic [VB-1:0] v, input logic [RADIX_W-1:0] r,
                       input digit_q_t spelled);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      value    <= VB'($urandom);
      radix    <= RADIX_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    radix    <= r;
    do @(posedge clk); while (!in_ready);
    foreach (spelled[i]) pending_digits.push_back(spelled[i]);
    @(negedge clk);
  endtask

  // sender
  initial begin
    digit_q_t           spelled;
    logic [VB-1:0]      v;
    logic [RADIX_W-1:0] r;
    digit_t             item;
    rst      = 1'b1;
    in_valid = 1'b0;
    value    = '0;
    radix    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      if (plan[k].spelled.len() == 0) begin
        spelled = spell_number(plan[k].number, plan[k].base);
      end else begin
        spelled = {};
        for (int i = 0; i < plan[k].spelled.len(); i++) begin
          item.ch   = 7'(plan[k].spelled[i]);
          item.last = (i == plan[k].spelled.len() - 1);
          item.bad  = plan[k].flagged;
          spelled.push_back(item);
        end
      end
      offer(plan[k].number, plan[k].base, spelled);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_tx = ((n / 32) % 4) == 3;
      case ($urandom_range(0, 3))
        0: v = VB'($urandom);
        1: v = VB'($urandom_range(0, 300));
        2: v = VB'($urandom) >> $urandom_range(0, VB - 1);
        default: v = $urandom_range(0, 1) ? ({VB{1'b1}} >> $urandom_range(0, VB - 1))
                                           : (VB'(1) << $urandom_range(0, VB - 1));
      endcase
      if ($urandom_range(0, 99) < 85) begin
        r = RADIX_W'($urandom_range(2, 16));
      end else begin
        r = RADIX_W'($urandom_range(0, 31));
      end
      offer(v, r, spell_number(v, r));
    end
    in_valid <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver, with one long hold-off to back the block up
  initial begin
    int unsigned stall;
    bit          held;
    out_ready = 1'b0;
    held = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!held && rx_count >= HOLD_AT) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else if (((rx_count / 64) % 4) == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      rx_count++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_digits
    digit_t exp_d;
    if (!rst && out_valid && out_ready) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected transfer: digit_char %0d last %0b bad_radix %0b",
               digit_char, last, bad_radix);
        mismatches++;
      end else begin
        exp_d = pending_digits.pop_front();
        if (digit_char !== exp_d.ch) begin
          $error("digit_char: expected %0d, got %0d", exp_d.ch, digit_char);
          mismatches++;
        end
        if (last !== exp_d.last) begin
          $error("last: expected %0b, got %0b", exp_d.last, last);
          mismatches++;
        end
        if (bad_radix !== exp_d.bad) begin
          $error("bad_radix: expected %0b, got %0b", exp_d.bad, bad_radix);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("timeout after %0d idle cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
